[rtl/core/vrpst_pkg.sv]
// Package: shared constants and codes for the video register port block.
`default_nettype none
package vrpst_pkg;
    localparam int NAMETABLE_BYTES_DEF = 2048;
    localparam int LAST_DOT_DEF        = 340;
    localparam int LAST_LINE_DEF       = 261;

    // item kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_DMA   = 2'd2;
    localparam logic [1:0] KIND_TICK  = 2'd3;

    // register numbers
    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_MASK   = 3'd1;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_OAMADR = 3'd3;
    localparam logic [2:0] REG_OAMDAT = 3'd4;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_ADDR   = 3'd6;
    localparam logic [2:0] REG_DATA   = 3'd7;

    // config register index
    localparam logic CFG_MIRROR = 1'b0;

    localparam logic [13:0] CHR_END     = 14'h2000;
    localparam logic [13:0] PALETTE_BEG = 14'h3F00;
    localparam logic [8:0]  LAST_VISIBLE_LINE = 9'd239;
    localparam logic [8:0]  VBLANK_LINE       = 9'd241;
endpackage
`default_nettype wire

[rtl/core/video_register_port_and_scroll_timing.sv]
// Top level: video chip register port, scroll address logic and dot/line timing.
// The result is registered and valid in the cycle after input accept; one item per cycle
// sustained. Outside the clearing pass, throughput is limited only by the result register:
// a new item enters in every cycle in which the result slot is free or is being taken.
// Reset (synchronous, active low) clears control state, then a clearing pass over every
// nametable entry zeroes nametable and sprite memory; no item is taken meanwhile.
`default_nettype none
module video_register_port_and_scroll_timing #(
    parameter int NAMETABLE_BYTES = vrpst_pkg::NAMETABLE_BYTES_DEF,
    parameter int LAST_DOT        = vrpst_pkg::LAST_DOT_DEF,
    parameter int LAST_LINE       = vrpst_pkg::LAST_LINE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config port
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [2:0]  i_reg_index,
    input  wire logic [7:0]  i_data_in,
    input  wire logic [7:0]  i_sprite_index,
    input  wire logic [7:0]  i_chr_byte,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_read_data,
    output logic             o_chr_write,
    output logic [12:0]      o_chr_address,
    output logic [7:0]       o_chr_write_data,
    output logic             o_nmi_pulse,
    output logic             o_vblank,
    output logic [8:0]       o_dot,
    output logic [8:0]       o_line
);
    import vrpst_pkg::*;

    localparam int NTW = $clog2(NAMETABLE_BYTES);
    localparam logic [8:0] LAST_DOT_V  = 9'(LAST_DOT);
    localparam logic [8:0] LAST_LINE_V = 9'(LAST_LINE);

    // ---------------- config register ----------------
    logic r_mirror_vertical;
    logic cfg_wr;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == CFG_MIRROR) ? {31'd0, r_mirror_vertical} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror_vertical <= 1'b0;
        end else if (cfg_wr && i_paddr[2] == CFG_MIRROR) begin
            r_mirror_vertical <= i_pwdata[0];
        end
    end

    // ---------------- clearing pass after reset ----------------
    // Sweeps every nametable entry; sprite memory is cleared in the first 256 steps.
    logic           r_clr_busy;
    logic [NTW-1:0] r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == NTW'(NAMETABLE_BYTES - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ---------------- handshake ----------------
    logic r_out_valid;
    logic accept;
    assign o_in_stall  = r_clr_busy || (r_out_valid && i_out_stall);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    // ---------------- architectural state ----------------
    logic [7:0]  r_ctrl, r_mask, r_read_buffer, r_sprite_addr;
    logic [2:0]  r_fine_x;
    logic        r_vblank_flag, r_toggle;
    logic [14:0] r_cur, r_tmp;
    logic [8:0]  r_dot_cnt, r_line_cnt;
    logic        r_buf_from_nt;   // read buffer lives in the nametable read register
    logic [7:0]  r_palette [32];

    // memories
    logic [7:0]  nt_mem [NAMETABLE_BYTES];
    logic [7:0]  spr_mem [256];
    logic [7:0]  r_nt_q, r_spr_q;

    // ---------------- next-state logic ----------------
    logic [7:0]     n_ctrl, n_mask, n_read_buffer, n_sprite_addr;
    logic [2:0]     n_fine_x;
    logic           n_vblank_flag, n_toggle, n_buf_from_nt;
    logic [14:0]    n_cur, n_tmp;
    logic [8:0]     n_dot_cnt, n_line_cnt;
    logic [7:0]     n_rd;
    logic           n_rd_spr, n_cw, n_nmi;
    logic [12:0]    n_caddr;
    logic [7:0]     n_cdata;
    logic           nt_we, nt_re, spr_we, spr_re, pal_we;
    logic [NTW-1:0] nt_idx;
    logic [7:0]     spr_wadr;
    logic [13:0]    a14;
    logic [14:0]    incr;
    logic [7:0]     eff_buffer;
    logic           pre, vis;
    logic [4:0]     yv;

    assign a14        = r_cur[13:0];
    assign incr       = r_ctrl[2] ? 15'd32 : 15'd1;
    assign eff_buffer = r_buf_from_nt ? r_nt_q : r_read_buffer;
    assign nt_idx     = r_mirror_vertical ? NTW'(r_cur[10:0])
                                          : NTW'({r_cur[11], r_cur[9:0]});

    always_comb begin
        n_ctrl        = r_ctrl;
        n_mask        = r_mask;
        n_read_buffer = r_read_buffer;
        n_buf_from_nt = r_buf_from_nt;
        n_sprite_addr = r_sprite_addr;
        n_fine_x      = r_fine_x;
        n_vblank_flag = r_vblank_flag;
        n_toggle      = r_toggle;
        n_cur         = r_cur;
        n_tmp         = r_tmp;
        n_dot_cnt     = r_dot_cnt;
        n_line_cnt    = r_line_cnt;
        n_rd          = 8'd0;
        n_rd_spr      = 1'b0;
        n_cw          = 1'b0;
        n_caddr       = 13'd0;
        n_cdata       = 8'd0;
        n_nmi         = 1'b0;
        nt_we         = 1'b0;
        nt_re         = 1'b0;
        spr_we        = 1'b0;
        spr_re        = 1'b0;
        pal_we        = 1'b0;
        spr_wadr      = r_sprite_addr;
        pre           = 1'b0;
        vis           = 1'b0;
        yv            = 5'd0;

        case (i_kind)
            KIND_READ: begin
                case (i_reg_index)
                    REG_STATUS: begin
                        n_rd          = {r_vblank_flag, 7'd0};
                        n_vblank_flag = 1'b0;
                        n_toggle      = 1'b0;
                    end
                    REG_OAMDAT: begin
                        n_rd_spr = 1'b1;
                        spr_re   = 1'b1;
                    end
                    REG_DATA: begin
                        n_rd = eff_buffer;
                        if (a14 < CHR_END) begin
                            n_read_buffer = i_chr_byte;
                            n_buf_from_nt = 1'b0;
                            n_caddr       = a14[12:0];
                        end else if (a14 < PALETTE_BEG) begin
                            nt_re         = 1'b1;
                            n_buf_from_nt = 1'b1;
                        end else begin
                            n_read_buffer = r_palette[a14[4:0]];
                            n_buf_from_nt = 1'b0;
                            n_rd          = r_palette[a14[4:0]];
                        end
                        n_cur = r_cur + incr;
                    end
                    default: ;
                endcase
            end
            KIND_WRITE: begin
                case (i_reg_index)
                    REG_CTRL: begin
                        n_ctrl        = i_data_in;
                        n_tmp[11:10]  = i_data_in[1:0];
                    end
                    REG_MASK:   n_mask        = i_data_in;
                    REG_OAMADR: n_sprite_addr = i_data_in;
                    REG_OAMDAT: begin
                        spr_we        = 1'b1;
                        n_sprite_addr = r_sprite_addr + 8'd1;
                    end
                    REG_SCROLL: begin
                        if (!r_toggle) begin
                            n_fine_x   = i_data_in[2:0];
                            n_tmp[4:0] = i_data_in[7:3];
                        end else begin
                            n_tmp[14:12] = i_data_in[2:0];
                            n_tmp[9:5]   = i_data_in[7:3];
                        end
                        n_toggle = !r_toggle;
                    end
                    REG_ADDR: begin
                        if (!r_toggle) begin
                            n_tmp[13:8] = i_data_in[5:0];
                            n_tmp[14]   = 1'b0;
                        end else begin
                            n_tmp[7:0] = i_data_in;
                            n_cur      = {r_tmp[14:8], i_data_in};
                        end
                        n_toggle = !r_toggle;
                    end
                    REG_DATA: begin
                        if (a14 < CHR_END) begin
                            n_cw    = 1'b1;
                            n_caddr = a14[12:0];
                            n_cdata = i_data_in;
                        end else if (a14 < PALETTE_BEG) begin
                            nt_we = 1'b1;
                        end else begin
                            pal_we = 1'b1;
                        end
                        n_cur = r_cur + incr;
                    end
                    default: ;
                endcase
            end
            KIND_DMA: begin
                spr_we   = 1'b1;
                spr_wadr = i_sprite_index;
            end
            default: begin
                // dot tick
                pre = (r_line_cnt == LAST_LINE_V);
                vis = (r_line_cnt <= LAST_VISIBLE_LINE);
                if (vis || pre) begin
                    if (r_line_cnt == 9'd0 && r_dot_cnt == 9'd0) begin
                        n_dot_cnt = 9'd1;   // skip of dot zero on line zero, taken every frame
                    end
                    if (pre && n_dot_cnt == 9'd1) begin
                        n_vblank_flag = 1'b0;
                    end
                    if (r_mask[4:3] != 2'b00) begin
                        if ((n_dot_cnt >= 9'd2 && n_dot_cnt <= 9'd257) ||
                            (n_dot_cnt >= 9'd321 && n_dot_cnt <= 9'd337)) begin
                            // coarse x step every eighth dot
                            if (n_dot_cnt[2:0] == 3'd0) begin
                                if (n_cur[4:0] == 5'd31) begin
                                    n_cur[4:0] = 5'd0;
                                    n_cur[10]  = !n_cur[10];
                                end else begin
                                    n_cur = n_cur + 15'd1;
                                end
                            end
                            // fine/coarse y step at end of visible dots
                            if (n_dot_cnt == 9'd256) begin
                                if (n_cur[14:12] != 3'd7) begin
                                    n_cur[14:12] = n_cur[14:12] + 3'd1;
                                end else begin
                                    n_cur[14:12] = 3'd0;
                                    yv = n_cur[9:5];
                                    if (yv == 5'd29) begin
                                        yv        = 5'd0;
                                        n_cur[11] = !n_cur[11];
                                    end else if (yv == 5'd31) begin
                                        yv = 5'd0;
                                    end else begin
                                        yv = yv + 5'd1;
                                    end
                                    n_cur[9:5] = yv;
                                end
                            end
                            if (n_dot_cnt == 9'd257) begin
                                n_cur[10]  = r_tmp[10];
                                n_cur[4:0] = r_tmp[4:0];
                            end
                        end else if (pre && n_dot_cnt >= 9'd280 && n_dot_cnt <= 9'd304) begin
                            n_cur[14:11] = r_tmp[14:11];
                            n_cur[9:5]   = r_tmp[9:5];
                        end
                    end
                end
                if (r_line_cnt == VBLANK_LINE && n_dot_cnt == 9'd1) begin
                    n_vblank_flag = 1'b1;
                    n_nmi         = r_ctrl[7];
                end
                n_dot_cnt = n_dot_cnt + 9'd1;
                if (n_dot_cnt > LAST_DOT_V) begin
                    n_dot_cnt  = 9'd0;
                    n_line_cnt = r_line_cnt + 9'd1;
                    if (n_line_cnt > LAST_LINE_V) begin
                        n_line_cnt = 9'd0;
                    end
                end
            end
        endcase
    end

    // ---------------- state registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl        <= 8'd0;
            r_mask        <= 8'd0;
            r_read_buffer <= 8'd0;
            r_buf_from_nt <= 1'b0;
            r_sprite_addr <= 8'd0;
            r_fine_x      <= 3'd0;
            r_vblank_flag <= 1'b0;
            r_toggle      <= 1'b0;
            r_cur         <= 15'd0;
            r_tmp         <= 15'd0;
            r_dot_cnt     <= 9'd0;
            r_line_cnt    <= 9'd0;
            for (int k = 0; k < 32; k++) begin
                r_palette[k] <= 8'd0;
            end
        end else if (accept) begin
            r_ctrl        <= n_ctrl;
            r_mask        <= n_mask;
            r_read_buffer <= n_read_buffer;
            r_buf_from_nt <= n_buf_from_nt;
            r_sprite_addr <= n_sprite_addr;
            r_fine_x      <= n_fine_x;
            r_vblank_flag <= n_vblank_flag;
            r_toggle      <= n_toggle;
            r_cur         <= n_cur;
            r_tmp         <= n_tmp;
            r_dot_cnt     <= n_dot_cnt;
            r_line_cnt    <= n_line_cnt;
            if (pal_we) begin
                r_palette[a14[4:0]] <= i_data_in;
            end
        end
    end

    // ---------------- memories ----------------
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            nt_mem[r_clr_cnt] <= 8'd0;
        end else if (accept && nt_we) begin
            nt_mem[nt_idx] <= i_data_in;
        end
        if (accept && nt_re) begin
            r_nt_q <= nt_mem[nt_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            if (r_clr_cnt < NTW'(256)) begin
                spr_mem[r_clr_cnt[7:0]] <= 8'd0;
            end
        end else if (accept && spr_we) begin
            spr_mem[spr_wadr] <= i_data_in;
        end
        if (accept && spr_re) begin
            r_spr_q <= spr_mem[r_sprite_addr];
        end
    end

    // ---------------- result register ----------------
    logic [7:0]  r_rd, r_cdata;
    logic        r_rd_spr, r_cw, r_nmi, r_vb_out;
    logic [12:0] r_caddr;
    logic [8:0]  r_dot_out, r_line_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd       <= n_rd;
            r_rd_spr   <= n_rd_spr;
            r_cw       <= n_cw;
            r_caddr    <= n_caddr;
            r_cdata    <= n_cdata;
            r_nmi      <= n_nmi;
            r_vb_out   <= n_vblank_flag;
            r_dot_out  <= n_dot_cnt;
            r_line_out <= n_line_cnt;
        end
    end

    // sprite data read comes straight from the memory's read register
    assign o_read_data      = r_rd_spr ? r_spr_q : r_rd;
    assign o_chr_write      = r_cw;
    assign o_chr_address    = r_caddr;
    assign o_chr_write_data = r_cdata;
    assign o_nmi_pulse      = r_nmi;
    assign o_vblank         = r_vb_out;
    assign o_dot            = r_dot_out;
    assign o_line           = r_line_out;

    // ---------------- assertions ----------------
    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !accept)
        else $error("item accepted during clearing pass");

    a_nmi_with_vblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_nmi) |-> r_vb_out)
        else $error("nmi pulse without vblank");

    a_chr_write_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_cw) |-> (o_read_data == 8'd0 && !r_rd_spr))
        else $error("pattern write with read data");

    a_dot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_dot_out <= LAST_DOT_V && r_line_out <= LAST_LINE_V))
        else $error("counter out of range");
endmodule
`default_nettype wire
